// File: sv/assert_macros.svh
// Assertion macros for the checker file of the decoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: sv/nir_pkg.sv
// Shared types, constants and window functions for the NEC IR frame decoder.
// Depends on nothing.
`default_nettype none

package nir_pkg;

   localparam int TIME_WIDTH_DEF = 16;
   localparam int TICK_W         = 16;
   localparam int TOL_W          = 8;
   localparam int FRAME_BITS     = 32;
   localparam int BIT_IDX_W      = $clog2(FRAME_BITS);
   localparam int BOUND_W        = TICK_W + TOL_W + 1;
   localparam int CSR_IDX_W      = 3;
   localparam int BYTE_W         = 8;

   localparam logic [CSR_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_SPACE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EXT_ADDRESS  = 3'd6;

   localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 16'd9000;
   localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 16'd4500;
   localparam logic [TICK_W-1:0] RST_BIT_MARK     = 16'd560;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 16'd560;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 16'd1690;
   localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 8'd64;
   localparam logic              RST_EXT_ADDRESS  = 1'b0;

   localparam logic KIND_PAIR    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   localparam logic [1:0] RK_NEW_FRAME    = 2'd0;
   localparam logic [1:0] RK_REPEAT_FRAME = 2'd1;
   localparam logic [1:0] RK_CHECK_ERROR  = 2'd2;
   localparam logic [1:0] RK_TIMING_ERROR = 2'd3;

   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
   localparam logic [TOL_W:0]    TOL_ONE   = (TOL_W+1)'(2**TOL_W);

   typedef struct packed {
      logic              kind;
      logic [TICK_W-1:0] mark_ticks;
      logic [TICK_W-1:0] space_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [TICK_W-1:0] address;
      logic [BYTE_W-1:0] command;
   } rsp_type;

   typedef struct packed {
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
   } window_type;

   typedef struct packed {
      window_type leader_mark;
      window_type leader_space;
      window_type repeat_space;
      window_type bit_mark;
      window_type zero_space;
      window_type one_space;
      logic       extended_address;
   } bounds_type;

   function automatic window_type make_window(logic [TICK_W-1:0] nominal,
                                              logic [TOL_W-1:0] tol);
      logic [TOL_W:0] up;
      logic [TOL_W:0] dn;
      window_type     w;
      up   = TOL_ONE + {1'b0, tol};
      dn   = TOL_ONE - {1'b0, tol};
      w.hi = BOUND_W'(nominal) * BOUND_W'(up);
      w.lo = BOUND_W'(nominal) * BOUND_W'(dn);
      return w;
   endfunction

   function automatic logic fits(logic [BOUND_W-1:0] scaled, window_type w);
      return (scaled <= w.hi) && (scaled >= w.lo);
   endfunction

endpackage

`default_nettype wire

// File: sv/nir_csr.sv
// Configuration registers and precomputed timing windows.
// Depends on nir_pkg.
`default_nettype none

module nir_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [nir_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nir_pkg::TICK_W-1:0]    csr_wdata,
   output nir_pkg::bounds_type                bounds
);

   logic [nir_pkg::TICK_W-1:0] leader_mark_ff;
   logic [nir_pkg::TICK_W-1:0] leader_space_ff;
   logic [nir_pkg::TICK_W-1:0] bit_mark_ff;
   logic [nir_pkg::TICK_W-1:0] zero_space_ff;
   logic [nir_pkg::TICK_W-1:0] one_space_ff;
   logic [nir_pkg::TOL_W-1:0]  tolerance_ff;
   logic                       ext_address_ff;
   nir_pkg::bounds_type        bounds_ff;
   nir_pkg::bounds_type        bounds_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_mark_ff  <= nir_pkg::RST_LEADER_MARK;
         leader_space_ff <= nir_pkg::RST_LEADER_SPACE;
         bit_mark_ff     <= nir_pkg::RST_BIT_MARK;
         zero_space_ff   <= nir_pkg::RST_ZERO_SPACE;
         one_space_ff    <= nir_pkg::RST_ONE_SPACE;
         tolerance_ff    <= nir_pkg::RST_TOLERANCE;
         ext_address_ff  <= nir_pkg::RST_EXT_ADDRESS;
      end else if (csr_wr_en) begin
         case (csr_index)
            nir_pkg::REG_LEADER_MARK:  leader_mark_ff  <= csr_wdata;
            nir_pkg::REG_LEADER_SPACE: leader_space_ff <= csr_wdata;
            nir_pkg::REG_BIT_MARK:     bit_mark_ff     <= csr_wdata;
            nir_pkg::REG_ZERO_SPACE:   zero_space_ff   <= csr_wdata;
            nir_pkg::REG_ONE_SPACE:    one_space_ff    <= csr_wdata;
            nir_pkg::REG_TOLERANCE:    tolerance_ff    <= csr_wdata[nir_pkg::TOL_W-1:0];
            nir_pkg::REG_EXT_ADDRESS:  ext_address_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      bounds_in.leader_mark      = nir_pkg::make_window(leader_mark_ff, tolerance_ff);
      bounds_in.leader_space     = nir_pkg::make_window(leader_space_ff, tolerance_ff);
      bounds_in.repeat_space     = nir_pkg::make_window(leader_space_ff >> 1, tolerance_ff);
      bounds_in.bit_mark         = nir_pkg::make_window(bit_mark_ff, tolerance_ff);
      bounds_in.zero_space       = nir_pkg::make_window(zero_space_ff, tolerance_ff);
      bounds_in.one_space        = nir_pkg::make_window(one_space_ff, tolerance_ff);
      bounds_in.extended_address = ext_address_ff;
   end

   always_ff @(posedge clock) begin
      bounds_ff <= bounds_in;
   end

   assign bounds = bounds_ff;

endmodule

`default_nettype wire

// File: sv/nir_frame.sv
// Frame state, window classification and result register.
// Depends on nir_pkg; windows come from nir_csr.
`default_nettype none

module nir_frame #(
   parameter  int TIME_WIDTH = nir_pkg::TIME_WIDTH_DEF,
   localparam int MEAS_W     = (TIME_WIDTH < nir_pkg::TICK_W) ? TIME_WIDTH
                                                              : nir_pkg::TICK_W
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic                                 in_kind,
   input  wire logic [MEAS_W-1:0]                    in_mark,
   input  wire logic [MEAS_W-1:0]                    in_space,
   input  wire nir_pkg::bounds_type                  bounds,
   output logic                                      advance,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output nir_pkg::rsp_type                          rsp_data
);

   logic                                leader_ff, leader_in;
   logic                                repeat_ff, repeat_in;
   logic [nir_pkg::BIT_IDX_W-1:0]       bit_idx_ff, bit_idx_in;
   logic [nir_pkg::FRAME_BITS-1:0]      shift_ff, shift_in;
   logic [nir_pkg::TICK_W-1:0]          prev_addr_ff, prev_addr_in;
   logic [nir_pkg::BYTE_W-1:0]          prev_cmd_ff, prev_cmd_in;
   logic                                rsp_valid_ff;
   nir_pkg::rsp_type                    rsp_data_ff;
   logic                                emit;
   nir_pkg::rsp_type                    result;
   logic [nir_pkg::BOUND_W-1:0]         mark_scaled;
   logic [nir_pkg::BOUND_W-1:0]         space_scaled;
   logic [nir_pkg::FRAME_BITS-1:0]      word;
   logic                                bit_val;
   logic [nir_pkg::BYTE_W-1:0]          addr_lo, addr_hi, cmd, cmd_n;
   logic                                frame_ok;
   logic [nir_pkg::TICK_W-1:0]          frame_addr;

   assign advance      = in_valid && (!rsp_valid_ff || rsp_ready);
   assign mark_scaled  = nir_pkg::BOUND_W'({in_mark, nir_pkg::TOL_W'(0)});
   assign space_scaled = nir_pkg::BOUND_W'({in_space, nir_pkg::TOL_W'(0)});

   always_comb begin
      bit_val = !nir_pkg::fits(space_scaled, bounds.zero_space);
      word    = shift_ff;
      word[bit_idx_ff] = shift_ff[bit_idx_ff] | bit_val;
      addr_lo = word[7:0];
      addr_hi = word[15:8];
      cmd     = word[23:16];
      cmd_n   = word[31:24];
      frame_ok = (cmd ^ cmd_n) == nir_pkg::BYTE_ONES;
      if (bounds.extended_address) begin
         frame_addr = word[15:0];
      end else begin
         frame_addr = {nir_pkg::BYTE_W'(0), addr_lo};
         frame_ok   = frame_ok && ((addr_lo ^ addr_hi) == nir_pkg::BYTE_ONES);
      end
   end

   always_comb begin
      leader_in    = leader_ff;
      repeat_in    = repeat_ff;
      bit_idx_in   = bit_idx_ff;
      shift_in     = shift_ff;
      prev_addr_in = prev_addr_ff;
      prev_cmd_in  = prev_cmd_ff;
      emit         = 1'b0;
      result       = '0;
      if (in_kind == nir_pkg::KIND_TIMEOUT) begin
         leader_in  = 1'b0;
         repeat_in  = 1'b0;
         bit_idx_in = '0;
         shift_in   = '0;
         if (repeat_ff) begin
            emit               = 1'b1;
            result.result_kind = nir_pkg::RK_REPEAT_FRAME;
            result.address     = prev_addr_ff;
            result.command     = prev_cmd_ff;
         end
      end else if (!leader_ff) begin
         if (nir_pkg::fits(mark_scaled, bounds.leader_mark)) begin
            if (nir_pkg::fits(space_scaled, bounds.leader_space)) begin
               leader_in = 1'b1;
            end else if (nir_pkg::fits(space_scaled, bounds.repeat_space)) begin
               repeat_in = 1'b1;
            end
         end
      end else if (!nir_pkg::fits(mark_scaled, bounds.bit_mark) ||
                   (!nir_pkg::fits(space_scaled, bounds.zero_space) &&
                    !nir_pkg::fits(space_scaled, bounds.one_space))) begin
         leader_in          = 1'b0;
         repeat_in          = 1'b0;
         bit_idx_in         = '0;
         shift_in           = '0;
         emit               = 1'b1;
         result.result_kind = nir_pkg::RK_TIMING_ERROR;
      end else if (bit_idx_ff == nir_pkg::BIT_IDX_W'(nir_pkg::FRAME_BITS - 1)) begin
         leader_in  = 1'b0;
         repeat_in  = 1'b0;
         bit_idx_in = '0;
         shift_in   = '0;
         emit       = 1'b1;
         if (frame_ok) begin
            prev_addr_in       = frame_addr;
            prev_cmd_in        = cmd;
            result.result_kind = nir_pkg::RK_NEW_FRAME;
            result.address     = frame_addr;
            result.command     = cmd;
         end else begin
            result.result_kind = nir_pkg::RK_CHECK_ERROR;
         end
      end else begin
         shift_in   = word;
         bit_idx_in = bit_idx_ff + nir_pkg::BIT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_ff    <= 1'b0;
         repeat_ff    <= 1'b0;
         bit_idx_ff   <= '0;
         shift_ff     <= '0;
         prev_addr_ff <= '0;
         prev_cmd_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            leader_ff    <= leader_in;
            repeat_ff    <= repeat_in;
            bit_idx_ff   <= bit_idx_in;
            shift_ff     <= shift_in;
            prev_addr_ff <= prev_addr_in;
            prev_cmd_ff  <= prev_cmd_in;
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/nec_ir_frame_decoder.sv
// Top level of the NEC IR frame decoder: input register and submodule wiring.
// Depends on nir_pkg, nir_csr and nir_frame.
//
//   channel   direction   handshake          payload
//   req       in          valid / ready      nir_pkg::req_type
//   rsp       out         valid / ready      nir_pkg::rsp_type
//   csr       in          write enable only  index, 16-bit data
//
// One item per cycle sustained while results are not stalled; a request passes
// through the input register and then the result register.
// Window bounds are computed from the configuration registers and registered again.
// Reset clears frame state, the previous frame and both valid flags.
// A stalled result holds the item in the input register; req_ready drops only then.
`default_nettype none

module nec_ir_frame_decoder #(
   parameter int TIME_WIDTH = nir_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire nir_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output nir_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [nir_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nir_pkg::TICK_W-1:0]    csr_wdata
);

   localparam int MEAS_W = (TIME_WIDTH < nir_pkg::TICK_W) ? TIME_WIDTH : nir_pkg::TICK_W;

   logic                in_valid_ff;
   logic                in_kind_ff;
   logic [MEAS_W-1:0]   in_mark_ff;
   logic [MEAS_W-1:0]   in_space_ff;
   logic                advance;
   logic                req_fire;
   nir_pkg::bounds_type bounds;

   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff  <= req_data.kind;
         in_mark_ff  <= req_data.mark_ticks[MEAS_W-1:0];
         in_space_ff <= req_data.space_ticks[MEAS_W-1:0];
      end
   end

   nir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   nir_frame #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_kind   (in_kind_ff),
      .in_mark   (in_mark_ff),
      .in_space  (in_space_ff),
      .bounds    (bounds),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: sv/nir_checker.sv
// Port-level checks of the NEC IR frame decoder, bound to the top level.
// Depends on nir_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nir_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire nir_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && (rsp_data.result_kind == nir_pkg::RK_CHECK_ERROR || rsp_data.result_kind == nir_pkg::RK_TIMING_ERROR), rsp_data.address == '0 && rsp_data.command == '0)
   `ASSERT_IMPLIES(a_rst_no_rsp, clock, reset, $past(reset), !rsp_valid)
   `ASSERT_IMPLIES(a_rst_ready, clock, reset, $past(reset), req_ready)

endmodule

bind nec_ir_frame_decoder nir_checker u_checker (.*);

`default_nettype wire
